FILE: design/walucc_pkg.sv
// ----------------------------------------------------------------------------
// walucc_pkg
// Operation codes and condition-code bit positions for the word ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package walucc_pkg;

  typedef enum logic [5:0] {
    OP_CLR  = 6'd0,
    OP_INC  = 6'd1,
    OP_DEC  = 6'd2,
    OP_ADC  = 6'd3,
    OP_SBC  = 6'd4,
    OP_TST  = 6'd5,
    OP_NEG  = 6'd6,
    OP_COM  = 6'd7,
    OP_ROR  = 6'd8,
    OP_ROL  = 6'd9,
    OP_ASR  = 6'd10,
    OP_ASL  = 6'd11,
    OP_SWAB = 6'd12,
    OP_SXT  = 6'd13,
    OP_MOV  = 6'd14,
    OP_ADD  = 6'd15,
    OP_SUB  = 6'd16,
    OP_CMP  = 6'd17,
    OP_BIS  = 6'd18,
    OP_BIC  = 6'd19,
    OP_BIT  = 6'd20,
    OP_XOR  = 6'd21,
    OP_BR   = 6'd22,
    OP_BNE  = 6'd23,
    OP_BEQ  = 6'd24,
    OP_BPL  = 6'd25,
    OP_BMI  = 6'd26,
    OP_BVC  = 6'd27,
    OP_BVS  = 6'd28,
    OP_BCC  = 6'd29,
    OP_BCS  = 6'd30,
    OP_BGE  = 6'd31,
    OP_BLT  = 6'd32,
    OP_BGT  = 6'd33,
    OP_BLE  = 6'd34,
    OP_BHI  = 6'd35,
    OP_BLOS = 6'd36,
    OP_CCOP = 6'd37
  } op_t;

  localparam int unsigned CC_C = 0;
  localparam int unsigned CC_V = 1;
  localparam int unsigned CC_Z = 2;
  localparam int unsigned CC_N = 3;

  localparam logic [15:0] WORD_SIGN = 16'h8000;
  localparam logic [15:0] WORD_MAXP = 16'h7FFF;
  localparam logic [15:0] WORD_ONES = 16'hFFFF;
  localparam logic [7:0]  BYTE_ZERO = 8'h00;

endpackage

`default_nettype wire

FILE: design/word_alu_condition_codes.sv
// ----------------------------------------------------------------------------
// word_alu_condition_codes
// 16-bit word ALU with N, Z, V and C condition codes and branch tests.
// ----------------------------------------------------------------------------
// One transaction is taken per cycle unless the output channel stalls. A
// request is held in an input register, evaluated in a single combinational
// pass against the condition-code register, and its result lands in the
// output register, from which it is offered on the output channel. The loop
// through the condition-code register sets the rate: each request sees the
// codes left by the one before it. The output register lets a new request
// enter while a finished result is still waiting to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module word_alu_condition_codes
  import walucc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  req_type,
  input  wire logic [15:0] src_word,
  input  wire logic [15:0] dst_word,
  input  wire logic [3:0]  cc_mask,
  input  wire logic        cc_set,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      result_word,
  output logic             write_back,
  output logic             flag_n,
  output logic             flag_z,
  output logic             flag_v,
  output logic             flag_c,
  output logic             branch_taken
);

  logic        req_valid;
  logic [5:0]  req_op;
  logic [15:0] req_src;
  logic [15:0] req_dst;
  logic [3:0]  req_mask;
  logic        req_set;

  logic [3:0]  cc;
  logic [3:0]  cc_next;
  logic [15:0] res_next;
  logic        wb_next;
  logic        br_next;
  logic        advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_op   <= req_type;
      req_src  <= src_word;
      req_dst  <= dst_word;
      req_mask <= cc_mask;
      req_set  <= cc_set;
    end
  end

  always_comb begin
    logic [16:0] wide;
    logic        cin;
    logic        co;
    logic        n;
    logic        z;
    logic        v;
    logic [15:0] r;
    cin  = cc[CC_C];
    n    = cc[CC_N];
    z    = cc[CC_Z];
    v    = cc[CC_V];
    wide = '0;
    co   = 1'b0;
    r    = '0;
    res_next = '0;
    wb_next  = 1'b0;
    br_next  = 1'b0;
    cc_next  = cc;
    case (req_op)
      OP_CLR: begin
        cc_next = 4'b0100;
        wb_next = 1'b1;
      end
      OP_INC, OP_DEC, OP_ADC, OP_SBC: begin
        r = req_dst;
        case (req_op)
          OP_INC:  r = req_dst + 16'd1;
          OP_DEC:  r = req_dst - 16'd1;
          OP_ADC:  r = req_dst + {15'd0, cin};
          OP_SBC:  r = req_dst - {15'd0, cin};
          default: r = req_dst;
        endcase
        res_next     = r;
        wb_next      = 1'b1;
        cc_next[CC_N] = r[15];
        cc_next[CC_Z] = (r == 16'd0);
        case (req_op)
          OP_INC: cc_next[CC_V] = (req_dst == WORD_MAXP);
          OP_DEC: cc_next[CC_V] = (req_dst == WORD_SIGN);
          OP_ADC: begin
            cc_next[CC_V] = cin && (req_dst == WORD_MAXP);
            cc_next[CC_C] = cin && (req_dst == WORD_ONES);
          end
          OP_SBC: begin
            cc_next[CC_V] = cin && (req_dst == WORD_SIGN);
            cc_next[CC_C] = cin && (req_dst == 16'd0);
          end
          default: cc_next[CC_V] = 1'b0;
        endcase
      end
      OP_TST: begin
        res_next = req_dst;
        cc_next  = {req_dst[15], (req_dst == 16'd0), 2'b00};
      end
      OP_NEG: begin
        r        = 16'd0 - req_dst;
        res_next = r;
        wb_next  = 1'b1;
        cc_next  = {r[15], (r == 16'd0), (r == WORD_SIGN), (r != 16'd0)};
      end
      OP_COM: begin
        r        = ~req_dst;
        res_next = r;
        wb_next  = 1'b1;
        cc_next  = {r[15], (r == 16'd0), 2'b01};
      end
      OP_ROR, OP_ROL, OP_ASR, OP_ASL: begin
        case (req_op)
          OP_ROR: begin
            r  = {cin, req_dst[15:1]};
            co = req_dst[0];
          end
          OP_ROL: begin
            r  = {req_dst[14:0], cin};
            co = req_dst[15];
          end
          OP_ASR: begin
            r  = {req_dst[15], req_dst[15:1]};
            co = req_dst[0];
          end
          default: begin
            r  = {req_dst[14:0], 1'b0};
            co = req_dst[15];
          end
        endcase
        res_next = r;
        wb_next  = 1'b1;
        cc_next  = {r[15], (r == 16'd0), r[15] ^ co, co};
      end
      OP_SWAB: begin
        r        = {req_dst[7:0], req_dst[15:8]};
        res_next = r;
        wb_next  = 1'b1;
        cc_next  = {r[7], (r[7:0] == BYTE_ZERO), 2'b00};
      end
      OP_SXT: begin
        res_next = n ? WORD_ONES : 16'd0;
        wb_next  = 1'b1;
        cc_next  = {n, !n, 1'b0, cin};
      end
      OP_MOV, OP_BIS, OP_BIC, OP_BIT, OP_XOR: begin
        case (req_op)
          OP_MOV:  r = req_src;
          OP_BIS:  r = req_src | req_dst;
          OP_BIC:  r = req_dst & ~req_src;
          OP_BIT:  r = req_src & req_dst;
          default: r = req_src ^ req_dst;
        endcase
        res_next = r;
        wb_next  = (req_op != OP_BIT);
        cc_next  = {r[15], (r == 16'd0), 1'b0, cin};
      end
      OP_ADD: begin
        wide     = {1'b0, req_src} + {1'b0, req_dst};
        r        = wide[15:0];
        res_next = r;
        wb_next  = 1'b1;
        cc_next  = {r[15], (r == 16'd0),
                    (req_src[15] == req_dst[15]) && (r[15] != req_src[15]), wide[16]};
      end
      OP_SUB: begin
        wide     = {1'b0, req_dst} - {1'b0, req_src};
        r        = wide[15:0];
        res_next = r;
        wb_next  = 1'b1;
        cc_next  = {r[15], (r == 16'd0),
                    (req_src[15] != req_dst[15]) && (r[15] == req_src[15]), wide[16]};
      end
      OP_CMP: begin
        wide     = {1'b0, req_src} - {1'b0, req_dst};
        r        = wide[15:0];
        res_next = r;
        cc_next  = {r[15], (r == 16'd0),
                    (req_src[15] != req_dst[15]) && (r[15] == req_dst[15]), wide[16]};
      end
      OP_BR:   br_next = 1'b1;
      OP_BNE:  br_next = !z;
      OP_BEQ:  br_next = z;
      OP_BPL:  br_next = !n;
      OP_BMI:  br_next = n;
      OP_BVC:  br_next = !v;
      OP_BVS:  br_next = v;
      OP_BCC:  br_next = !cin;
      OP_BCS:  br_next = cin;
      OP_BGE:  br_next = (n == v);
      OP_BLT:  br_next = (n != v);
      OP_BGT:  br_next = !(z || (n != v));
      OP_BLE:  br_next = z || (n != v);
      OP_BHI:  br_next = !(cin || z);
      OP_BLOS: br_next = cin || z;
      OP_CCOP: cc_next = req_set ? (cc | req_mask) : (cc & ~req_mask);
      default: cc_next = cc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cc        <= 4'b0000;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        cc        <= cc_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      result_word  <= res_next;
      write_back   <= wb_next;
      branch_taken <= br_next;
    end
  end

  assign flag_n = cc[CC_N];
  assign flag_z = cc[CC_Z];
  assign flag_v = cc[CC_V];
  assign flag_c = cc[CC_C];

  a_br_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken |-> !write_back)
    else $error("branch result marked for write-back");

  a_cc_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cc))
    else $error("condition codes moved without a transaction");

  a_fill_output: assert property (@(posedge clk) disable iff (rst)
    req_valid && !out_valid |=> out_valid)
    else $error("held request did not reach the output register");

  a_branch_keeps_cc: assert property (@(posedge clk) disable iff (rst)
    advance && br_next |=> cc == $past(cc))
    else $error("branch test altered the condition codes");

endmodule

`default_nettype wire
